// ===== design/polar_offset_heading_assert.svh =====
// Assertion macros for the polar_offset_heading block.
`ifndef POLAR_OFFSET_HEADING_ASSERT_SVH
`define POLAR_OFFSET_HEADING_ASSERT_SVH

`ifndef SYNTHESIS

`define POH_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("polar_offset_heading: assertion failed");

`define POH_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("polar_offset_heading: assertion failed");

`else

`define POH_ASSERT_IMPL(label, clk, rstn, ante, cons)

`define POH_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== design/poh_pkg.sv =====
// Shared types and constants for the polar_offset_heading block.
package poh_pkg;

    localparam int Z_W = 26;           // angle width, 1/65536 degree units

    typedef logic signed [Z_W-1:0] z_t;

    typedef struct packed {
        logic valid;
        logic tag;                     // flip in rotation, zero vector in vectoring
    } ctl_t;

    localparam logic [15:0] GAIN_Q16 = 16'd39797;
    localparam logic [8:0]  DEG_FULL = 9'd360;
    localparam z_t ANG_HALF = z_t'(180 * 65536);
    localparam z_t ANG_FULL = z_t'(360 * 65536);
    localparam int MAX_STEPS = 24;

    // atan(2^-i) in degrees * 65536
    function automatic z_t atan_q16(input int idx);
        z_t a;
        case (idx)
            0:  a = z_t'(2949120);
            1:  a = z_t'(1740967);
            2:  a = z_t'(919879);
            3:  a = z_t'(466945);
            4:  a = z_t'(234379);
            5:  a = z_t'(117304);
            6:  a = z_t'(58666);
            7:  a = z_t'(29335);
            8:  a = z_t'(14668);
            9:  a = z_t'(7334);
            10: a = z_t'(3667);
            11: a = z_t'(1833);
            12: a = z_t'(917);
            13: a = z_t'(458);
            14: a = z_t'(229);
            15: a = z_t'(115);
            16: a = z_t'(57);
            17: a = z_t'(29);
            18: a = z_t'(14);
            19: a = z_t'(7);
            20: a = z_t'(4);
            21: a = z_t'(2);
            22: a = z_t'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== design/poh_cordic_cell.sv =====
// One registered CORDIC micro-rotation, rotation or vectoring mode.
module poh_cordic_cell import poh_pkg::*; #(
    parameter int VW        = 29,
    parameter int STEP      = 0,
    parameter bit VECTORING = 1'b0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  ctl_t                 ctl_in,
    input  logic signed [VW-1:0] x_in,
    input  logic signed [VW-1:0] y_in,
    input  z_t                   z_in,
    output ctl_t                 ctl_out,
    output logic signed [VW-1:0] x_out,
    output logic signed [VW-1:0] y_out,
    output z_t                   z_out
);

    localparam z_t ATAN = atan_q16(STEP);

    ctl_t                 ctl_reg;
    logic signed [VW-1:0] x_reg, x_next;
    logic signed [VW-1:0] y_reg, y_next;
    z_t                   z_reg, z_next;
    logic signed [VW-1:0] xs, ys;
    logic                 ccw;

    assign xs  = x_in >>> STEP;
    assign ys  = y_in >>> STEP;
    // vectoring drives y toward zero, rotation drives z toward zero
    assign ccw = VECTORING ? y_in[VW-1] : !z_in[Z_W-1];

    always_comb begin
        if (ccw) begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ATAN;
        end else begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;

endmodule

// ===== design/polar_offset_heading.sv =====
// Top level: polar-to-Cartesian rotation, offset, and atan2 heading pipeline.
//
// Input channel s_*: one item is a bearing (degrees) and a distance. Result
// channel m_*: one item per input, the heading in whole degrees 0..359 toward
// the target point shifted down in y by target_offset. cfg_* writes
// target_offset; cfg_ready is always high, write only while the block is idle.
// N = min(CORDIC_STEPS, 24). An accepted item passes the input register, the
// N rotation cells, post stages A and B, the N vectoring cells and the output
// register. Throughput: one item per cycle while the skid entry is empty, set
// by the row of CORDIC cells, each doing one micro-rotation per cycle.
// The whole pipeline advances together; an output register plus one skid
// entry follow it. When the receiver stalls, the skid entry catches the next
// finished item and the pipeline then holds with s_ready low until m_ready
// drains it.
// Reset (aresetn low, synchronous) empties the pipeline, the output and skid
// registers, and sets target_offset to 0.
module polar_offset_heading import poh_pkg::*; #(
    parameter int CORDIC_STEPS  = 16,
    parameter int DISTANCE_BITS = 10
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [9:0]               cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [8:0]               s_ball_angle,
    input  logic [DISTANCE_BITS-1:0] s_ball_distance,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [8:0]               m_follow_angle
);

`include "polar_offset_heading_assert.svh"

    localparam int N  = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;
    localparam int VW = ((DISTANCE_BITS > 10) ? DISTANCE_BITS : 10) + 19;
    localparam int PW = DISTANCE_BITS + 16;

    logic [9:0] target_offset_reg;
    logic       en;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_offset_reg <= '0;
        end else if (cfg_valid) begin
            target_offset_reg <= cfg_data;
        end
    end

    // ---------------- input stage: range reduction and gain ----------------
    logic [8:0]        ang_red;
    logic signed [9:0] ang_rot;
    logic              flip;
    logic [PW-1:0]     prod;

    ctl_t                 in_ctl_reg;
    logic signed [VW-1:0] in_x_reg;
    z_t                   in_z_reg;

    assign ang_red = (s_ball_angle >= DEG_FULL) ? s_ball_angle - DEG_FULL : s_ball_angle;

    always_comb begin
        flip = 1'b0;
        if (ang_red > 9'd90 && ang_red <= 9'd270) begin
            ang_rot = $signed({1'b0, ang_red}) - 10'sd180;
            flip    = 1'b1;
        end else if (ang_red > 9'd270) begin
            ang_rot = $signed({1'b0, ang_red}) - 10'sd360;
        end else begin
            ang_rot = $signed({1'b0, ang_red});
        end
    end

    assign prod = PW'(s_ball_distance) * PW'(GAIN_Q16);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_ctl_reg <= '0;
        end else if (en) begin
            in_ctl_reg <= '{valid: s_valid, tag: flip};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_x_reg <= $signed({{(VW-PW){1'b0}}, prod});
            in_z_reg <= z_t'({ang_rot, 16'h0000});
        end
    end

    assign s_ready = en;

    // ---------------- rotation cells ----------------
    ctl_t                 rc [0:N];
    logic signed [VW-1:0] rx [0:N];
    logic signed [VW-1:0] ry [0:N];
    z_t                   rz [0:N];

    assign rc[0] = in_ctl_reg;
    assign rx[0] = in_x_reg;
    assign ry[0] = '0;
    assign rz[0] = in_z_reg;

    for (genvar i = 0; i < N; i++) begin : g_rot
        poh_cordic_cell #(.VW(VW), .STEP(i), .VECTORING(1'b0)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctl_in  (rc[i]),
            .x_in    (rx[i]),
            .y_in    (ry[i]),
            .z_in    (rz[i]),
            .ctl_out (rc[i+1]),
            .x_out   (rx[i+1]),
            .y_out   (ry[i+1]),
            .z_out   (rz[i+1])
        );
    end

    // ---------------- post stage A: undo quadrant fold, apply offset -------
    logic signed [VW-1:0] off_wide;
    logic signed [VW-1:0] xa_next, ya_next, ya_flip;
    ctl_t                 pa_ctl_reg;
    logic signed [VW-1:0] pa_x_reg, pa_y_reg;

    assign off_wide = $signed({{(VW-26){target_offset_reg[9]}}, target_offset_reg, 16'h0000});
    assign xa_next  = rc[N].tag ? -rx[N] : rx[N];
    assign ya_flip  = rc[N].tag ? -ry[N] : ry[N];
    assign ya_next  = ya_flip - off_wide;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pa_ctl_reg <= '0;
        end else if (en) begin
            pa_ctl_reg <= '{valid: rc[N].valid, tag: 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pa_x_reg <= xa_next;
            pa_y_reg <= ya_next;
        end
    end

    // ---------------- post stage B: zero check, fold into right half -------
    logic                 is_zero, x_neg;
    ctl_t                 pb_ctl_reg;
    logic signed [VW-1:0] pb_x_reg, pb_y_reg;
    z_t                   pb_z_reg;

    assign is_zero = (pa_x_reg == '0) && (pa_y_reg == '0);
    assign x_neg   = pa_x_reg[VW-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pb_ctl_reg <= '0;
        end else if (en) begin
            pb_ctl_reg <= '{valid: pa_ctl_reg.valid, tag: is_zero};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pb_x_reg <= x_neg ? -pa_x_reg : pa_x_reg;
            pb_y_reg <= x_neg ? -pa_y_reg : pa_y_reg;
            pb_z_reg <= x_neg ? ANG_HALF : '0;
        end
    end

    // ---------------- vectoring cells ----------------
    ctl_t                 vc [0:N];
    logic signed [VW-1:0] vx [0:N];
    logic signed [VW-1:0] vy [0:N];
    z_t                   vz [0:N];

    assign vc[0] = pb_ctl_reg;
    assign vx[0] = pb_x_reg;
    assign vy[0] = pb_y_reg;
    assign vz[0] = pb_z_reg;

    for (genvar i = 0; i < N; i++) begin : g_vec
        poh_cordic_cell #(.VW(VW), .STEP(i), .VECTORING(1'b1)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctl_in  (vc[i]),
            .x_in    (vx[i]),
            .y_in    (vy[i]),
            .z_in    (vz[i]),
            .ctl_out (vc[i+1]),
            .x_out   (vx[i+1]),
            .y_out   (vy[i+1]),
            .z_out   (vz[i+1])
        );
    end

    // ---------------- final: wrap, truncate toward zero, 0..359 ----------
    z_t         z_wrap, z_mag;
    logic [9:0] whole;
    logic [8:0] heading;
    logic       last_valid;

    assign last_valid = vc[N].valid;

    always_comb begin
        if (vz[N] > ANG_HALF) begin
            z_wrap = vz[N] - ANG_FULL;
        end else if (vz[N] <= -ANG_HALF) begin
            z_wrap = vz[N] + ANG_FULL;
        end else begin
            z_wrap = vz[N];
        end
        z_mag = z_wrap[Z_W-1] ? -z_wrap : z_wrap;
        whole = z_mag[Z_W-1:16];
        if (vc[N].tag) begin
            heading = '0;
        end else if (z_wrap[Z_W-1] && whole != '0) begin
            heading = 9'(10'(DEG_FULL) - whole);
        end else begin
            heading = 9'(whole);
        end
    end

    // ---------------- output register and skid entry ----------------
    logic       m_valid_reg;
    logic [8:0] m_data_reg;
    logic       skid_full_reg;
    logic [8:0] skid_data_reg;

    assign en = !skid_full_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            skid_full_reg <= 1'b0;
        end else if (skid_full_reg) begin
            if (m_ready) begin
                skid_full_reg <= 1'b0;
            end
        end else if (last_valid) begin
            if (!m_valid_reg || m_ready) begin
                m_valid_reg <= 1'b1;
            end else begin
                skid_full_reg <= 1'b1;
            end
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_full_reg) begin
            if (m_ready) begin
                m_data_reg <= skid_data_reg;
            end
        end else if (last_valid) begin
            if (!m_valid_reg || m_ready) begin
                m_data_reg <= heading;
            end else begin
                skid_data_reg <= heading;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_follow_angle = m_data_reg;

    // ---------------- checks ----------------
    `POH_ASSERT_IMPL(a_skid_has_out, aclk, aresetn, skid_full_reg, m_valid_reg)
    `POH_ASSERT_NEXT(a_stall_fills_skid, aclk, aresetn,
        m_valid_reg && !m_ready && last_valid && !skid_full_reg, skid_full_reg)
    `POH_ASSERT_NEXT(a_skid_drains, aclk, aresetn, skid_full_reg && m_ready,
        m_valid_reg && !skid_full_reg)
    `POH_ASSERT_IMPL(a_heading_range, aclk, aresetn, m_valid_reg, m_data_reg < DEG_FULL)

endmodule

// ===== tb/sv/polar_offset_heading_test.sv =====
// Testbench for polar_offset_heading: random and corner-case headings checked by a scoreboard.
module polar_offset_heading_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int    STEPS    = 16;
    localparam int    DIST_W   = 10;
    localparam longint ANG_ONE = 65536;
    localparam longint GAIN    = 39797;
    localparam longint FULL    = 360;
    localparam int    SETTLE   = 2 * STEPS + 8;   // pipeline depth plus margin

    // atan(2^-i) in degrees, Q16
    localparam longint ARC_DEG [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    class heading_board;
        logic signed [9:0] offset;
        logic [8:0]        due_q[$];
        int unsigned       n_checked;
        int unsigned       n_errors;

        function new();
            offset    = '0;
            n_checked = 0;
            n_errors  = 0;
        endfunction

        function void set_offset(logic signed [9:0] v);
            offset = v;
        endfunction

        function logic [8:0] predict(logic [8:0] bearing, logic [DIST_W-1:0] distance);
            longint a, x, y, z, xs, ys, t;
            bit flip;
            a    = longint'(bearing);
            flip = 1'b0;
            if (a >= FULL) a -= FULL;
            if (a > 90 && a <= 270) begin
                a -= 180;
                flip = 1'b1;
            end else if (a > 270) begin
                a -= FULL;
            end
            // rotate (d*K, 0) by the bearing
            z = a * ANG_ONE;
            x = longint'(distance) * GAIN;
            y = 0;
            for (int i = 0; i < STEPS; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x = x - ys;
                    y = y + xs;
                    z -= ARC_DEG[i];
                end else begin
                    x = x + ys;
                    y = y - xs;
                    z += ARC_DEG[i];
                end
            end
            if (flip) begin
                x = -x;
                y = -y;
            end
            y -= longint'(offset) * ANG_ONE;
            // vectoring back to an angle
            if (x == 0 && y == 0) return 9'd0;
            z = 0;
            if (x < 0) begin
                x = -x;
                y = -y;
                z = 180 * ANG_ONE;
            end
            for (int i = 0; i < STEPS; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys;
                    y = y - xs;
                    z += ARC_DEG[i];
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z -= ARC_DEG[i];
                end
            end
            if (z > 180 * ANG_ONE) z -= FULL * ANG_ONE;
            if (z <= -180 * ANG_ONE) z += FULL * ANG_ONE;
            t = z / ANG_ONE;                  // truncates toward zero
            if (t < 0) t += FULL;
            if (t >= FULL) t -= FULL;
            return t[8:0];
        endfunction

        function void note_item(logic [8:0] bearing, logic [DIST_W-1:0] distance);
            due_q.push_back(predict(bearing, distance));
        endfunction

        function void check_result(logic [8:0] got);
            logic [8:0] want;
            if (due_q.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual %0d", $time, got);
                n_errors++;
                return;
            end
            want = due_q.pop_front();
            n_checked++;
            if (got !== want) begin
                $display("%0t: follow_angle mismatch, expected %0d, actual %0d",
                         $time, want, got);
                n_errors++;
            end
        endfunction
    endclass

    logic              aclk            = 1'b0;
    logic              aresetn         = 1'b0;
    logic              cfg_valid       = 1'b0;
    logic              cfg_ready;
    logic [9:0]        cfg_data        = '0;
    logic              s_valid         = 1'b0;
    logic              s_ready;
    logic [8:0]        s_ball_angle    = '0;
    logic [DIST_W-1:0] s_ball_distance = '0;
    logic              m_valid;
    logic              m_ready         = 1'b0;
    logic [8:0]        m_follow_angle;

    heading_board board = new();
    bit          steady    = 1'b0;   // no idling on either side
    bit          long_hold = 1'b0;   // receiver backs off for a long stretch
    int unsigned n_sent    = 0;
    int unsigned n_offsets = 1;

    polar_offset_heading #(
        .CORDIC_STEPS  (STEPS),
        .DISTANCE_BITS (DIST_W)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_ball_angle    (s_ball_angle),
        .s_ball_distance (s_ball_distance),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_follow_angle  (m_follow_angle)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_follow_angle);
    end

    // receiver
    initial begin
        int unsigned r;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            r = $urandom_range(0, 99);
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                long_hold = 1'b0;
            end else if (steady || r < 65) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                if (r < 95) repeat ($urandom_range(1, 3)) @(posedge aclk);
                else repeat ($urandom_range(12, 40)) @(posedge aclk);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("polar_offset_heading_test: errors");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    task automatic push_item(input logic [8:0] bearing, input logic [DIST_W-1:0] distance);
        int unsigned gap;
        s_valid         <= 1'b1;
        s_ball_angle    <= bearing;
        s_ball_distance <= distance;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_item(bearing, distance);
        n_sent++;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic push_random(input int unsigned count);
        logic [8:0]        bearing;
        logic [DIST_W-1:0] distance;
        int unsigned       r;
        for (int unsigned k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                bearing = 9'($urandom_range(360, 511));
            end else if (r < 22) begin
                case ($urandom_range(0, 6))
                    0:       bearing = 9'd0;
                    1:       bearing = 9'd90;
                    2:       bearing = 9'd91;
                    3:       bearing = 9'd180;
                    4:       bearing = 9'd270;
                    5:       bearing = 9'd271;
                    default: bearing = 9'd359;
                endcase
            end else begin
                bearing = 9'($urandom_range(0, 359));
            end
            r = $urandom_range(0, 99);
            if (r < 15) distance = DIST_W'($urandom_range(0, 3));
            else if (r < 25) distance = DIST_W'(1023 - $urandom_range(0, 3));
            else distance = DIST_W'($urandom_range(0, 1023));
            push_item(bearing, distance);
        end
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // sender holds until every heading is back, then lets the pipe settle
    task automatic wait_idle();
        while (board.due_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_offset(input logic signed [9:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.set_offset(v);
        n_offsets++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // zero distance, where the offset alone sets the heading, and full distance at 90 and 270
    task automatic offset_corners();
        push_item(9'd0, '0);
        push_item(9'd90, DIST_W'(1023));
        push_item(9'd270, DIST_W'(1023));
        push_item(9'd180, '0);
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset offset: zero vector, rotation range edges, out-of-range bearings
        push_item(9'd0, '0);
        push_item(9'd90, '0);
        push_item(9'd511, '0);
        push_item(9'd0, DIST_W'(1023));
        push_item(9'd90, DIST_W'(1023));
        push_item(9'd91, DIST_W'(1023));
        push_item(9'd180, DIST_W'(1023));
        push_item(9'd270, DIST_W'(1023));
        push_item(9'd271, DIST_W'(1023));
        push_item(9'd359, DIST_W'(1023));
        push_item(9'd360, DIST_W'(500));
        push_item(9'd511, DIST_W'(1023));
        push_item(9'd45, DIST_W'(1));
        push_item(9'd135, DIST_W'(700));
        push_item(9'd225, DIST_W'(700));
        push_item(9'd315, DIST_W'(700));
        push_item(9'd179, DIST_W'(1));
        push_item(9'd181, DIST_W'(1));
        push_item(9'd0, DIST_W'(1));
        push_item(9'd300, DIST_W'(512));
        push_random(200);
        wait_idle();

        write_offset(-10'sd512);
        offset_corners();
        long_hold = 1'b1;
        push_random(200);
        wait_idle();

        write_offset(10'sd511);
        offset_corners();
        steady = 1'b1;
        push_random(200);
        steady = 1'b0;
        wait_idle();

        write_offset(10'($urandom_range(0, 1023)));
        push_random(200);
        wait_idle();

        write_offset(10'($urandom_range(0, 15)) - 10'sd8);
        push_random(200);
        wait_idle();

        write_offset('0);
        push_random(200);
        wait_idle();

        if (board.due_q.size() != 0) begin
            $display("%0t: %0d headings never arrived", $time, board.due_q.size());
            board.n_errors++;
        end
        $display("Sent %0d bearings under %0d offset settings, %0d headings checked.",
                 n_sent, n_offsets, board.n_checked);
        if (board.n_errors == 0) begin
            $display("polar_offset_heading_test: clean");
        end else begin
            $display("polar_offset_heading_test: errors");
        end
        $finish;
    end
endmodule
